>>> src/tmsg_pkg.sv
// Shared types, constants and register map of the trimmed mean sensor guard.
package tmsg_pkg;

    localparam int unsigned SAMPLE_W        = 10;
    localparam int unsigned SUM_W           = 16;
    localparam int unsigned CHAN_W          = 3;
    localparam int unsigned STATUS_W        = 2;
    localparam int unsigned NUM_REGS        = 8;
    localparam int unsigned CFG_IDX_W       = $clog2(NUM_REGS);
    localparam int unsigned DEFAULT_SAMPLES = 8;
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_GREEN = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WARN  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TRIP  = 2'd2;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIP_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIP_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_WARN_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_WARN_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_TRIP_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_TRIP_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_WARN_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_WARN_HIGH = 3'd7;

    localparam logic [SAMPLE_W-1:0] CFG_RESET [NUM_REGS] = '{
        10'd0, 10'd1023, 10'd0, 10'd1023,
        10'd0, 10'd1023, 10'd0, 10'd1023
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]   channel;
        logic                sensor_kind;
    } samp_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel_out;
        logic                kind_out;
        logic [SAMPLE_W-1:0] mean;
        logic [STATUS_W-1:0] status;
        logic                relay_open;
    } res_word_t;

    // Completed window as handed from the front end to the back end
    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [CHAN_W-1:0]   channel;
        logic                kind;
    } win_t;

endpackage

>>> src/trimmed_mean_sensor_guard.sv
// A completed window passes through the queue entry, then the trim, multiply and output registers.
// One sample word per cycle while the queue can take a completed window; one result per SAMPLES words.
// The accumulator closes a window in the accepting cycle; a two-entry queue feeds a
// three-stage back end (trim, reciprocal multiply, limit check into the output register).
// Reset clears the window (minimum to full scale), empties queue and pipeline and sets
// every limit register to its default; no clearing pass is needed.
module trimmed_mean_sensor_guard #(
    parameter int unsigned SAMPLES = tmsg_pkg::DEFAULT_SAMPLES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           samp_valid,
    output logic                           samp_ready,
    input  tmsg_pkg::samp_word_t           samp,
    output logic                           res_valid,
    input  logic                           res_ready,
    output tmsg_pkg::res_word_t            res,
    input  logic                           cfg_we,
    input  logic [tmsg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tmsg_pkg::SAMPLE_W-1:0]  cfg_wdata
);
    import tmsg_pkg::*;

    logic push;
    logic push_ready;
    win_t push_data;
    logic head_valid;
    logic pop;
    win_t head;

    tmsg_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samp_valid (samp_valid),
        .samp_ready (samp_ready),
        .samp       (samp),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tmsg_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .head_valid (head_valid),
        .pop        (pop),
        .head       (head)
    );

    tmsg_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .pop        (pop),
        .head       (head),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

endmodule

>>> src/tmsg_front.sv
// Window accumulator: running sum, minimum, maximum and fill count.
module tmsg_front #(
    parameter int unsigned SAMPLES = tmsg_pkg::DEFAULT_SAMPLES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                samp_valid,
    output logic                samp_ready,
    input  tmsg_pkg::samp_word_t samp,
    output logic                push,
    input  logic                push_ready,
    output tmsg_pkg::win_t      push_data
);
    import tmsg_pkg::*;

    localparam int unsigned CNT_W = $clog2(SAMPLES);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES - 1);

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] lo_reg, lo_next;
    logic [SAMPLE_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                last;
    logic                accept;

    // Fold the incoming word into the window
    always_comb
    begin
        sum_next = sum_reg + SUM_W'(samp.sample);
        lo_next  = (samp.sample < lo_reg) ? samp.sample : lo_reg;
        hi_next  = (samp.sample > hi_reg) ? samp.sample : hi_reg;
    end

    assign last       = (cnt_reg == LAST);
    assign samp_ready = push_ready || !last;
    assign accept     = samp_valid && samp_ready;
    assign push       = accept && last;

    always_comb
    begin
        push_data.sum     = sum_next;
        push_data.lo      = lo_next;
        push_data.hi      = hi_next;
        push_data.channel = samp.channel;
        push_data.kind    = samp.sensor_kind;
    end

    // Advance the window, restart it once it is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            lo_reg  <= SAMPLE_MAX;
            hi_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                sum_reg <= '0;
                lo_reg  <= SAMPLE_MAX;
                hi_reg  <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                lo_reg  <= lo_next;
                hi_reg  <= hi_next;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

endmodule

>>> src/tmsg_fifo.sv
// Short queue of completed windows between the front and back ends.
module tmsg_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           push_ready,
    input  tmsg_pkg::win_t push_data,
    output logic           head_valid,
    input  logic           pop,
    output tmsg_pkg::win_t head
);
    import tmsg_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    win_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    // Store the incoming window
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/tmsg_back.sv
// Trim, constant divide, limit check and result register, with the limit registers.
module tmsg_back #(
    parameter int unsigned SAMPLES = tmsg_pkg::DEFAULT_SAMPLES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               head_valid,
    output logic                               pop,
    input  tmsg_pkg::win_t                     head,
    output logic                               res_valid,
    input  logic                               res_ready,
    output tmsg_pkg::res_word_t                res,
    input  logic                               cfg_we,
    input  logic [tmsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmsg_pkg::SAMPLE_W-1:0]      cfg_wdata
);
    import tmsg_pkg::*;

    // Divide by the trimmed count as multiply by a rounded-up reciprocal and shift
    localparam int unsigned DIV    = SAMPLES - 2;
    localparam int unsigned SH     = SUM_W + $clog2(DIV);
    localparam int unsigned MUL_W  = SUM_W + 2;
    localparam int unsigned PROD_W = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] MUL = MUL_W'((longint'(1) << SH) / DIV + 1);

    logic [SAMPLE_W-1:0] cfg_reg [NUM_REGS];

    logic                s1_valid_reg;
    logic [SUM_W-1:0]    s1_trim_reg;
    logic [CHAN_W-1:0]   s1_chan_reg;
    logic                s1_kind_reg;

    logic                s2_valid_reg;
    logic [PROD_W-1:0]   s2_prod_reg;
    logic [CHAN_W-1:0]   s2_chan_reg;
    logic                s2_kind_reg;

    logic                out_valid_reg;
    res_word_t           out_reg, out_next;

    logic                out_free;
    logic                s2_load;
    logic                s1_load;

    logic [SUM_W-1:0]    quot;
    logic [SAMPLE_W-1:0] mean_c;
    logic [SAMPLE_W-1:0] trip_lo, trip_hi, warn_lo, warn_hi;
    logic [STATUS_W-1:0] status_c;

    // Stall control: each stage moves when the one ahead is free
    assign out_free = !out_valid_reg || res_ready;
    assign s2_load  = !s2_valid_reg || out_free;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign pop      = head_valid && s1_load;

    // Hold the limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Valid bits of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= head_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Drop minimum and maximum, then multiply by the reciprocal
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_trim_reg <= head.sum - SUM_W'(head.lo) - SUM_W'(head.hi);
            s1_chan_reg <= head.channel;
            s1_kind_reg <= head.kind;
        end
        if (s2_load)
        begin
            s2_prod_reg <= PROD_W'(s1_trim_reg) * PROD_W'(MUL);
            s2_chan_reg <= s1_chan_reg;
            s2_kind_reg <= s1_kind_reg;
        end
        if (out_free)
        begin
            out_reg <= out_next;
        end
    end

    // Shift out the quotient and clamp to the converter range
    always_comb
    begin
        quot   = SUM_W'(s2_prod_reg >> SH);
        mean_c = (quot > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX : quot[SAMPLE_W-1:0];
    end

    // Pick the limits of the sensor kind
    always_comb
    begin
        if (s2_kind_reg)
        begin
            trip_lo = cfg_reg[REG_CURR_TRIP_LOW];
            trip_hi = cfg_reg[REG_CURR_TRIP_HIGH];
            warn_lo = cfg_reg[REG_CURR_WARN_LOW];
            warn_hi = cfg_reg[REG_CURR_WARN_HIGH];
        end
        else
        begin
            trip_lo = cfg_reg[REG_TEMP_TRIP_LOW];
            trip_hi = cfg_reg[REG_TEMP_TRIP_HIGH];
            warn_lo = cfg_reg[REG_TEMP_WARN_LOW];
            warn_hi = cfg_reg[REG_TEMP_WARN_HIGH];
        end
    end

    // Classify: trip takes priority over warning
    always_comb
    begin
        if (mean_c < trip_lo || mean_c > trip_hi)
        begin
            status_c = STATUS_TRIP;
        end
        else if (mean_c <= warn_lo || mean_c >= warn_hi)
        begin
            status_c = STATUS_WARN;
        end
        else
        begin
            status_c = STATUS_GREEN;
        end
        out_next.channel_out = s2_chan_reg;
        out_next.kind_out    = s2_kind_reg;
        out_next.mean        = mean_c;
        out_next.status      = status_c;
        out_next.relay_open  = (status_c == STATUS_TRIP);
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

>>> src/tmsg_checker.sv
// Port-level checks on the result channel of the sensor guard, bound to the top level.
module tmsg_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input tmsg_pkg::res_word_t res
);
    import tmsg_pkg::*;

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // A stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // Relay request follows the trip status exactly
    a_relay: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.relay_open == (res.status == STATUS_TRIP)))
        else $error("relay request disagrees with status");

    // Only green, warning or trip is reported
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.status == STATUS_GREEN || res.status == STATUS_WARN ||
                       res.status == STATUS_TRIP))
        else $error("undefined status code");

endmodule

bind trimmed_mean_sensor_guard tmsg_checker u_tmsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the trimmed mean sensor guard: window means and limit status.
module testbench;
    import tmsg_pkg::*;

    localparam int unsigned SAMPLES       = DEFAULT_SAMPLES;
    localparam int unsigned DIR_WORDS     = 24;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_WORDS   = 72;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned REPORT_LIMIT  = 10;

    // One directed word, with an optional hand-written result and a limit change before it
    typedef struct packed {
        logic       relimit;
        samp_word_t word;
        logic       pinned;
        res_word_t  want;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 samp_valid;
    logic                 samp_ready;
    samp_word_t           samp;
    logic                 res_valid;
    logic                 res_ready;
    res_word_t            res;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0]  cfg_wdata;

    // Mirror of the limit registers and the open window
    logic [SAMPLE_W-1:0]  limit_reg [NUM_REGS];
    logic [SUM_W-1:0]     win_sum;
    logic [SAMPLE_W-1:0]  win_lo;
    logic [SAMPLE_W-1:0]  win_hi;
    int unsigned          win_fill;

    res_word_t            pending_results [$];
    int unsigned          err_count = 0;
    bit                   quiet = 1'b0;

    trimmed_mean_sensor_guard #(
        .SAMPLES(SAMPLES)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .samp_valid (samp_valid),
        .samp_ready (samp_ready),
        .samp       (samp),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Grade a mean against the limits of its sensor kind; trip wins over warn
    function automatic logic [STATUS_W-1:0] grade_mean(input logic [SAMPLE_W-1:0] m,
                                                       input logic kind);
        logic [SAMPLE_W-1:0] tlo;
        logic [SAMPLE_W-1:0] thi;
        logic [SAMPLE_W-1:0] wlo;
        logic [SAMPLE_W-1:0] whi;
        tlo = kind ? limit_reg[REG_CURR_TRIP_LOW]  : limit_reg[REG_TEMP_TRIP_LOW];
        thi = kind ? limit_reg[REG_CURR_TRIP_HIGH] : limit_reg[REG_TEMP_TRIP_HIGH];
        wlo = kind ? limit_reg[REG_CURR_WARN_LOW]  : limit_reg[REG_TEMP_WARN_LOW];
        whi = kind ? limit_reg[REG_CURR_WARN_HIGH] : limit_reg[REG_TEMP_WARN_HIGH];
        if (m < tlo || m > thi)
            return STATUS_TRIP;
        if (m <= wlo || m >= whi)
            return STATUS_WARN;
        return STATUS_GREEN;
    endfunction

    // Fold one sample word into the window; return 1 with the result when it closes
    function automatic bit fold_sample(input samp_word_t w, output res_word_t r);
        logic [SUM_W-1:0] trimmed;
        int unsigned      quot;
        r = '0;
        win_sum = win_sum + SUM_W'(w.sample);
        if (w.sample > win_hi)
            win_hi = w.sample;
        if (w.sample < win_lo)
            win_lo = w.sample;
        win_fill++;
        if (win_fill < SAMPLES)
            return 1'b0;
        trimmed = win_sum - SUM_W'(win_lo) - SUM_W'(win_hi);
        quot = trimmed / (SAMPLES - 2);
        if (quot > SAMPLE_MAX)
            quot = int'(SAMPLE_MAX);
        r.channel_out = w.channel;
        r.kind_out    = w.sensor_kind;
        r.mean        = SAMPLE_W'(quot);
        r.status      = grade_mean(r.mean, w.sensor_kind);
        r.relay_open  = (r.status == STATUS_TRIP);
        win_sum  = '0;
        win_lo   = SAMPLE_MAX;
        win_hi   = '0;
        win_fill = 0;
        return 1'b1;
    endfunction

    // Offer one sample word, idling first now and then; queue its result once taken
    task automatic put_word(input samp_word_t w, input bit pinned, input res_word_t pin_res);
        int        gap;
        res_word_t r;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            samp_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
        samp_valid <= 1'b1;
        samp       <= w;
        do
            @(posedge clk);
        while (!samp_ready);
        if (fold_sample(w, r))
            pending_results.push_back(pinned ? pin_res : r);
    endtask

    // Drop valid, wait for every queued result and let the pipeline run dry
    task automatic settle();
        samp_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all limit registers, one per cycle
    task automatic program_limits(input logic [SAMPLE_W-1:0] lim [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we       <= 1'b1;
            cfg_index    <= CFG_IDX_W'(i);
            cfg_wdata    <= lim[i];
            limit_reg[i] = lim[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Stall the result side in random bursts, none in the quiet tail
    initial
    begin
        int stall;
        stall = 0;
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (quiet)
                res_ready <= 1'b1;
            else if (stall > 0)
            begin
                res_ready <= 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                res_ready <= 1'b0;
                stall = $urandom_range(1, 15) - 1;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // Compare each taken result word with the oldest expectation
    initial
    begin
        res_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $display("%0t: result word with none expected: ",
                                 $realtime,
                                 "ch %0d kind %0d mean %0d status %0d relay %0d",
                                 res.channel_out, res.kind_out, res.mean,
                                 res.status, res.relay_open);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res.channel_out !== want.channel_out || res.kind_out !== want.kind_out ||
                        res.mean !== want.mean || res.status !== want.status ||
                        res.relay_open !== want.relay_open)
                    begin
                        err_count++;
                        if (err_count <= REPORT_LIMIT)
                            $display("%0t: mismatch: ", $realtime,
                                     "expected ch %0d kind %0d mean %0d status %0d relay %0d",
                                     want.channel_out, want.kind_out, want.mean,
                                     want.status, want.relay_open,
                                     ", got ch %0d kind %0d mean %0d status %0d relay %0d",
                                     res.channel_out, res.kind_out,
                                     res.mean, res.status, res.relay_open);
                    end
                end
            end
        end
    end

    // Abandon a run that hangs
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus
    initial
    begin
        dir_row_t            dir_rows [DIR_WORDS];
        logic [SAMPLE_W-1:0] lim [NUM_REGS];
        int                  q [$];
        int                  mode;
        int                  centre;
        int                  spread;
        int                  val;
        logic [CHAN_W-1:0]   win_chan;
        logic                win_kind;
        bit                  mixed;
        bit                  k;
        samp_word_t          w;

        rst_n      <= 1'b0;
        samp_valid <= 1'b0;
        samp       <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_wdata  <= '0;
        limit_reg  = CFG_RESET;
        win_sum    = '0;
        win_lo     = SAMPLE_MAX;
        win_hi     = '0;
        win_fill   = 0;

        // Full scale window, zero window, then mixed labels with crossed current limits
        dir_rows = '{
            '{1'b0, '{10'd1023, 3'd7, 1'b1}, 1'b0, '0},
            '{1'b0, '{10'd1023, 3'd7, 1'b1}, 1'b0, '0},
            '{1'b0, '{10'd1023, 3'd7, 1'b1}, 1'b0, '0},
            '{1'b0, '{10'd1023, 3'd7, 1'b1}, 1'b0, '0},
            '{1'b0, '{10'd1023, 3'd7, 1'b1}, 1'b0, '0},
            '{1'b0, '{10'd1023, 3'd7, 1'b1}, 1'b0, '0},
            '{1'b0, '{10'd1023, 3'd7, 1'b1}, 1'b0, '0},
            '{1'b0, '{10'd1023, 3'd7, 1'b1}, 1'b1, '{3'd7, 1'b1, 10'd1023, STATUS_WARN, 1'b0}},
            '{1'b0, '{10'd0, 3'd0, 1'b0}, 1'b0, '0},
            '{1'b0, '{10'd0, 3'd0, 1'b0}, 1'b0, '0},
            '{1'b0, '{10'd0, 3'd0, 1'b0}, 1'b0, '0},
            '{1'b0, '{10'd0, 3'd0, 1'b0}, 1'b0, '0},
            '{1'b0, '{10'd0, 3'd0, 1'b0}, 1'b0, '0},
            '{1'b0, '{10'd0, 3'd0, 1'b0}, 1'b0, '0},
            '{1'b0, '{10'd0, 3'd0, 1'b0}, 1'b0, '0},
            '{1'b0, '{10'd0, 3'd0, 1'b0}, 1'b1, '{3'd0, 1'b0, 10'd0, STATUS_WARN, 1'b0}},
            '{1'b1, '{10'd0, 3'd0, 1'b0}, 1'b0, '0},
            '{1'b0, '{10'd1023, 3'd1, 1'b1}, 1'b0, '0},
            '{1'b0, '{10'd600, 3'd2, 1'b0}, 1'b0, '0},
            '{1'b0, '{10'd600, 3'd3, 1'b1}, 1'b0, '0},
            '{1'b0, '{10'd600, 3'd4, 1'b0}, 1'b0, '0},
            '{1'b0, '{10'd600, 3'd5, 1'b1}, 1'b0, '0},
            '{1'b0, '{10'd600, 3'd6, 1'b0}, 1'b0, '0},
            '{1'b0, '{10'd600, 3'd5, 1'b1}, 1'b1, '{3'd5, 1'b1, 10'd600, STATUS_TRIP, 1'b1}}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIR_WORDS; i++)
        begin
            if (dir_rows[i].relimit)
            begin
                settle();
                // Current limits crossed, warn band overlapping the trip band
                lim = CFG_RESET;
                lim[REG_CURR_TRIP_LOW]  = 10'd900;
                lim[REG_CURR_TRIP_HIGH] = 10'd100;
                lim[REG_CURR_WARN_LOW]  = 10'd800;
                program_limits(lim);
            end
            put_word(dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].want);
        end

        // Random phases, each with its own limit setting
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            if (p == PHASES - 1)
                quiet = 1'b1;
            if (p == 0)
                lim = CFG_RESET;
            else if (p == 1)
                lim = '{default: SAMPLE_MAX};
            else if (p == 2)
                lim = '{default: '0};
            else
            begin
                for (int kk = 0; kk < 2; kk++)
                begin
                    k = kk[0];
                    q = {};
                    repeat (4) q.push_back($urandom_range(0, 1023));
                    // Keep most settings ordered, leave some crossed
                    if ($urandom_range(0, 4) != 0)
                        q.sort();
                    lim[k ? REG_CURR_TRIP_LOW  : REG_TEMP_TRIP_LOW]  = SAMPLE_W'(q[0]);
                    lim[k ? REG_CURR_WARN_LOW  : REG_TEMP_WARN_LOW]  = SAMPLE_W'(q[1]);
                    lim[k ? REG_CURR_WARN_HIGH : REG_TEMP_WARN_HIGH] = SAMPLE_W'(q[2]);
                    lim[k ? REG_CURR_TRIP_HIGH : REG_TEMP_TRIP_HIGH] = SAMPLE_W'(q[3]);
                end
            end
            program_limits(lim);

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Pick the shape of the next window
                if (n % SAMPLES == 0)
                begin
                    mode     = $urandom_range(0, 9);
                    centre   = $urandom_range(0, 1023);
                    spread   = $urandom_range(0, 64);
                    win_chan = CHAN_W'($urandom_range(0, 7));
                    win_kind = 1'($urandom_range(0, 1));
                    mixed    = ($urandom_range(0, 4) == 0);
                end
                if (mode == 0)
                    val = $urandom_range(0, 1023);
                else if (mode == 1)
                    val = $urandom_range(0, 1) ? int'(SAMPLE_MAX) : 0;
                else
                begin
                    val = centre + $urandom_range(0, 2 * spread) - spread;
                    if (val < 0)
                        val = 0;
                    if (val > int'(SAMPLE_MAX))
                        val = int'(SAMPLE_MAX);
                end
                w.sample      = SAMPLE_W'(val);
                w.channel     = mixed ? CHAN_W'($urandom_range(0, 7)) : win_chan;
                w.sensor_kind = mixed ? 1'($urandom_range(0, 1)) : win_kind;
                put_word(w, 1'b0, '0);
            end
        end

        // Drain and report
        settle();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
